@@ src/rslt_pkg.sv @@
// shared types and constants for the record slot table
`timescale 1ns / 1ps

package rslt_pkg;

  // table geometry
  localparam int SLOTS_DEFAULT  = 64;
  localparam int SLOTS_IN_USE_W = 7;
  localparam int KEY_W          = 31;
  localparam int ID_W           = 16;
  localparam int NAME_W         = 64;
  localparam int SLOT_W         = 6;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_SLOTS_IN_USE = 2'd0;
  localparam logic [1:0] REG_KEY_MIN      = 2'd1;
  localparam logic [1:0] REG_KEY_MAX      = 2'd2;

  // config reset values
  localparam logic [SLOTS_IN_USE_W-1:0] SLOTS_IN_USE_RESET = 7'd64;
  localparam logic [KEY_W-1:0]          KEY_MIN_RESET      = '0;
  localparam logic [KEY_W-1:0]          KEY_MAX_RESET      = '1;

  typedef enum logic [2:0] {
    ACT_INSERT_AT   = 3'd0,
    ACT_INSERT_FREE = 3'd1,
    ACT_MODIFY      = 3'd2,
    ACT_DELETE      = 3'd3,
    ACT_FIND_FREE   = 3'd4,
    ACT_FIND_ID     = 3'd5,
    ACT_READ        = 3'd6,
    ACT_CLEAR       = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SLOT  = 3'd1,
    ST_OCCUPIED  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_KEY   = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_PROBE,
    S_SCAN,
    S_CLEAR,
    S_RESULT
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_word;
    logic [ID_W-1:0]   search_id;
  } rslt_in_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] result_slot;
    logic [ID_W-1:0]   result_id;
    logic [KEY_W-1:0]  result_key;
    logic [NAME_W-1:0] result_name;
  } rslt_out_t;

  // one stored slot
  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
  } rslt_entry_t;

  localparam int ENTRY_W = $bits(rslt_entry_t);

endpackage

@@ src/rslt_ram.sv @@
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps

module rslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/record_slot_table.sv @@
// Record slot table: SLOTS records (valid mark, id, key, name word) held in one
// RAM and served by a small sequencer. One command is worked at a time;
// cmd_stall stays high until its result is handed to the output register. Read,
// modify, delete and insert at a slot pass through the lookup, probe and result
// states; a slot out of range goes from lookup straight to result. Insert first
// free, find free and find id walk the RAM one slot a cycle from slot 0, below
// min(slots_in_use, SLOTS), and stop at the first hit. Clear writes every slot
// of the RAM once. After reset the same clearing pass runs with cmd_stall high;
// configuration writes are taken throughout.
`timescale 1ns / 1ps

module record_slot_table
  import rslt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  rslt_in_t           cmd,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rslt_out_t          rsp,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int LIM_W = ($clog2(SLOTS + 1) > SLOTS_IN_USE_W) ?
                         $clog2(SLOTS + 1) : SLOTS_IN_USE_W;

  // configuration registers
  logic [SLOTS_IN_USE_W-1:0] slots_in_use;
  logic [KEY_W-1:0]          key_min;
  logic [KEY_W-1:0]          key_max;

  // sequencer state
  state_t             state;
  state_t             state_next;
  rslt_in_t           item;
  rslt_out_t          result;
  rslt_out_t          result_next;
  logic               result_load;
  logic [ID_W-1:0]    last_id;
  logic [IDX_W-1:0]   clr_idx;
  logic               clr_cmd;
  logic [LIM_W-1:0]   scan_idx;
  logic               pend;
  logic [LIM_W-1:0]   pend_idx;
  logic               scan_issue;
  logic               id_take;

  // ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  rslt_entry_t        ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  rslt_entry_t        rd;
  logic [ENTRY_W-1:0] ram_rdata;

  // decoded conditions
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   slot_ext;
  logic               slot_bad;
  logic               key_ok;
  logic               is_scan;
  logic               hit;
  logic               scan_end;
  logic               clr_done;
  logic               rsp_free;
  logic [ID_W-1:0]    id_inc;
  logic [ID_W-1:0]    new_id;

  // configuration write and read
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RESET;
      key_min      <= KEY_MIN_RESET;
      key_max      <= KEY_MAX_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SLOTS_IN_USE: slots_in_use <= pwdata[SLOTS_IN_USE_W-1:0];
        REG_KEY_MIN:      key_min      <= pwdata[KEY_W-1:0];
        REG_KEY_MAX:      key_max      <= pwdata[KEY_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SLOTS_IN_USE: prdata = PDATA_W'(slots_in_use);
      REG_KEY_MIN:      prdata = PDATA_W'(key_min);
      REG_KEY_MAX:      prdata = PDATA_W'(key_max);
      default:          prdata = '0;
    endcase
  end

  // record storage
  rslt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = rslt_entry_t'(ram_rdata);

  // shared checks on the current command
  assign lim = (LIM_W'(slots_in_use) < LIM_W'(SLOTS)) ? LIM_W'(slots_in_use)
                                                       : LIM_W'(SLOTS);
  assign slot_ext = LIM_W'(item.slot);
  assign slot_bad = (slot_ext >= lim);
  assign key_ok   = (item.key >= key_min) && (item.key <= key_max);
  assign hit      = (item.action == ACT_FIND_ID) ? (rd.vld && (rd.id == item.search_id))
                                                 : !rd.vld;
  assign scan_end = !pend && (scan_idx >= lim);
  assign clr_done = (clr_idx == IDX_W'(SLOTS - 1));
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign id_inc   = last_id + ID_W'(1);
  assign new_id   = (id_inc == '0) ? ID_W'(1) : id_inc;

  always_comb begin
    case (item.action) inside
      ACT_INSERT_FREE, ACT_FIND_FREE, ACT_FIND_ID: is_scan = 1'b1;
      default:                                     is_scan = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (item.action == ACT_CLEAR) begin
          state_next = S_CLEAR;
        end else if (is_scan) begin
          state_next = S_SCAN;
        end else if (slot_bad) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: state_next = S_RESULT;
      S_SCAN: begin
        if ((pend && hit) || scan_end) begin
          state_next = S_RESULT;
        end
      end
      S_CLEAR: begin
        if (clr_done) begin
          state_next = clr_cmd ? S_RESULT : S_IDLE;
        end
      end
      S_RESULT: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram control and result build
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = clr_idx;
    ram_wdata   = '0;
    ram_raddr   = scan_idx[IDX_W-1:0];
    result_load = 1'b0;
    result_next = '0;
    id_take     = 1'b0;
    scan_issue  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        // valid mark cleared, rest left as zero
        ram_we = 1'b1;
      end
      S_LOOKUP: begin
        ram_raddr = slot_ext[IDX_W-1:0];
        if (item.action == ACT_CLEAR) begin
          result_load        = 1'b1;
          result_next.status = ST_OK;
        end else if (!is_scan && slot_bad) begin
          result_load        = 1'b1;
          result_next.status = ST_BAD_SLOT;
        end
      end
      S_PROBE: begin
        result_load = 1'b1;
        ram_waddr   = slot_ext[IDX_W-1:0];
        unique case (item.action)
          ACT_INSERT_AT: begin
            if (rd.vld) begin
              result_next.status = ST_OCCUPIED;
            end else if (!key_ok) begin
              result_next.status = ST_BAD_KEY;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{vld: 1'b1, id: new_id, key: item.key, name: item.name_word};
              id_take   = 1'b1;
              result_next = '{status: ST_OK, result_slot: item.slot, result_id: new_id,
                              result_key: item.key, result_name: item.name_word};
            end
          end
          ACT_MODIFY: begin
            if (!rd.vld) begin
              result_next.status = ST_EMPTY;
            end else if (!key_ok) begin
              result_next.status = ST_BAD_KEY;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{vld: 1'b1, id: rd.id, key: item.key, name: item.name_word};
              result_next = '{status: ST_OK, result_slot: item.slot, result_id: rd.id,
                              result_key: item.key, result_name: item.name_word};
            end
          end
          ACT_DELETE: begin
            if (!rd.vld) begin
              result_next.status = ST_EMPTY;
            end else begin
              ram_we                  = 1'b1;
              ram_wdata               = rd;
              ram_wdata.vld           = 1'b0;
              result_next.status      = ST_OK;
              result_next.result_slot = item.slot;
            end
          end
          ACT_READ: begin
            if (!rd.vld) begin
              result_next.status = ST_EMPTY;
            end else begin
              result_next = '{status: ST_OK, result_slot: item.slot, result_id: rd.id,
                              result_key: rd.key, result_name: rd.name};
            end
          end
          default: result_next.status = ST_OK;
        endcase
      end
      S_SCAN: begin
        ram_waddr  = pend_idx[IDX_W-1:0];
        scan_issue = (scan_idx < lim);
        if (pend && hit) begin
          result_load = 1'b1;
          unique case (item.action)
            ACT_INSERT_FREE: begin
              if (!key_ok) begin
                result_next.status = ST_BAD_KEY;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = '{vld: 1'b1, id: new_id, key: item.key, name: item.name_word};
                id_take   = 1'b1;
                result_next = '{status: ST_OK, result_slot: pend_idx[SLOT_W-1:0],
                                result_id: new_id, result_key: item.key,
                                result_name: item.name_word};
              end
            end
            ACT_FIND_ID: begin
              result_next = '{status: ST_OK, result_slot: pend_idx[SLOT_W-1:0],
                              result_id: rd.id, result_key: rd.key, result_name: rd.name};
            end
            default: begin
              result_next.status      = ST_OK;
              result_next.result_slot = pend_idx[SLOT_W-1:0];
            end
          endcase
        end else if (scan_end) begin
          result_load        = 1'b1;
          result_next.status = (item.action == ACT_FIND_ID) ? ST_NOT_FOUND : ST_FULL;
        end
      end
      default: ;
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      clr_cmd <= 1'b0;
      last_id <= '0;
      pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (id_take) begin
        last_id <= new_id;
      end
      // clearing sweep
      if (state == S_LOOKUP && item.action == ACT_CLEAR) begin
        clr_idx <= '0;
        clr_cmd <= 1'b1;
      end else if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      // scan walk, one read in flight
      if (state == S_LOOKUP) begin
        pend <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= scan_issue;
      end
    end
  end

  // command and scan payload
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      item <= cmd;
    end
    if (state == S_LOOKUP) begin
      scan_idx <= '0;
    end else if (state == S_SCAN && scan_issue) begin
      scan_idx <= scan_idx + LIM_W'(1);
      pend_idx <= scan_idx;
    end
    if (result_load) begin
      result <= result_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESULT && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && rsp_free) begin
      rsp <= result;
    end
  end

endmodule

@@ tb/sv/tb_record_slot_table.sv @@
// self-checking testbench for the record slot table: directed and random commands, own table model
`timescale 1ns / 1ps

module tb_record_slot_table;
  import rslt_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int CHURN_PAIRS     = 16;
  localparam int DRAIN_CYCLES    = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  rslt_in_t           cmd = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rslt_out_t          rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // table model state and its copy of the registers
  logic [SLOTS_DEFAULT-1:0] held_valid = '0;
  logic [ID_W-1:0]          held_id   [SLOTS_DEFAULT];
  logic [KEY_W-1:0]         held_key  [SLOTS_DEFAULT];
  logic [NAME_W-1:0]        held_name [SLOTS_DEFAULT];
  logic [ID_W-1:0]          id_counter = '0;
  logic [SLOTS_IN_USE_W-1:0] cfg_slots = SLOTS_IN_USE_RESET;
  logic [KEY_W-1:0]         cfg_key_lo = KEY_MIN_RESET;
  logic [KEY_W-1:0]         cfg_key_hi = KEY_MAX_RESET;

  rslt_in_t  cmd_queue[$];
  rslt_out_t awaited_rsp[$];

  logic cmd_fired = 1'b0;
  logic rsp_fired = 1'b0;
  int   cmd_gap = 0;
  int   cmd_gap_max = 9;
  int   rsp_wait = 0;
  int   rsp_wait_max = 9;
  logic pressure_arm = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  record_slot_table uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // table model helpers
  function automatic logic key_in_range(logic [KEY_W-1:0] k);
    return k >= cfg_key_lo && k <= cfg_key_hi;
  endfunction

  function automatic logic [ID_W-1:0] next_record_id();
    id_counter = id_counter + 1'b1;
    if (id_counter == '0) id_counter = ID_W'(1);
    return id_counter;
  endfunction

  function automatic int first_free(int lim);
    int hit;
    hit = -1;
    for (int i = lim - 1; i >= 0; i--) if (!held_valid[i]) hit = i;
    return hit;
  endfunction

  function automatic void store_record(int s, logic [ID_W-1:0] id, logic [KEY_W-1:0] k,
                                       logic [NAME_W-1:0] nm);
    held_id[s]    = id;
    held_key[s]   = k;
    held_name[s]  = nm;
    held_valid[s] = 1'b1;
  endfunction

  function automatic rslt_out_t record_at(int s);
    rslt_out_t r;
    r = '0;
    r.result_slot = SLOT_W'(s);
    r.result_id   = held_id[s];
    r.result_key  = held_key[s];
    r.result_name = held_name[s];
    return r;
  endfunction

  // apply one command to the model table and return the response it must produce
  function automatic rslt_out_t apply_command(rslt_in_t c);
    rslt_out_t r;
    status_t   st;
    int        lim;
    int        hit;
    lim = (cfg_slots < SLOTS_DEFAULT) ? int'(cfg_slots) : SLOTS_DEFAULT;
    r   = '0;
    st  = ST_OK;
    hit = -1;
    case (c.action)
      ACT_INSERT_AT: begin
        if (c.slot >= lim) st = ST_BAD_SLOT;
        else if (held_valid[c.slot]) st = ST_OCCUPIED;
        else if (!key_in_range(c.key)) st = ST_BAD_KEY;
        else begin
          store_record(int'(c.slot), next_record_id(), c.key, c.name_word);
          r = record_at(int'(c.slot));
        end
      end
      ACT_INSERT_FREE: begin
        hit = first_free(lim);
        if (hit < 0) st = ST_FULL;
        else if (!key_in_range(c.key)) st = ST_BAD_KEY;
        else begin
          store_record(hit, next_record_id(), c.key, c.name_word);
          r = record_at(hit);
        end
      end
      ACT_MODIFY: begin
        if (c.slot >= lim) st = ST_BAD_SLOT;
        else if (!held_valid[c.slot]) st = ST_EMPTY;
        else if (!key_in_range(c.key)) st = ST_BAD_KEY;
        else begin
          store_record(int'(c.slot), held_id[c.slot], c.key, c.name_word);
          r = record_at(int'(c.slot));
        end
      end
      ACT_DELETE: begin
        if (c.slot >= lim) st = ST_BAD_SLOT;
        else if (!held_valid[c.slot]) st = ST_EMPTY;
        else begin
          held_valid[c.slot] = 1'b0;
          r.result_slot = c.slot;
        end
      end
      ACT_FIND_FREE: begin
        hit = first_free(lim);
        if (hit < 0) st = ST_FULL;
        else r.result_slot = SLOT_W'(hit);
      end
      ACT_FIND_ID: begin
        // lowest matching slot wins when ids recur
        for (int i = lim - 1; i >= 0; i--)
          if (held_valid[i] && held_id[i] == c.search_id) hit = i;
        if (hit < 0) st = ST_NOT_FOUND;
        else r = record_at(hit);
      end
      ACT_READ: begin
        if (c.slot >= lim) st = ST_BAD_SLOT;
        else if (!held_valid[c.slot]) st = ST_EMPTY;
        else r = record_at(int'(c.slot));
      end
      default: begin
        held_valid = '0;
      end
    endcase
    if (st != ST_OK) r = '0;
    r.status = st;
    return r;
  endfunction

  // stimulus helpers
  function automatic void queue_command(action_t a, logic [SLOT_W-1:0] s, logic [KEY_W-1:0] k,
                                        logic [NAME_W-1:0] nm, logic [ID_W-1:0] sid);
    rslt_in_t c;
    c.action    = a;
    c.slot      = s;
    c.key       = k;
    c.name_word = nm;
    c.search_id = sid;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    longint unsigned span;
    if (cfg_key_lo > cfg_key_hi || $urandom_range(0, 9) < 2) return KEY_W'($urandom);
    case ($urandom_range(0, 3))
      0: return cfg_key_lo;
      1: return cfg_key_hi;
      default: begin
        span = cfg_key_hi - cfg_key_lo + 1;
        return cfg_key_lo + KEY_W'($urandom % span);
      end
    endcase
  endfunction

  // mostly well-formed commands aimed at the addressable slots and at live ids
  function automatic rslt_in_t random_command(int spread);
    rslt_in_t c;
    int       lim;
    int       pick;
    lim  = (cfg_slots < SLOTS_DEFAULT) ? int'(cfg_slots) : SLOTS_DEFAULT;
    pick = $urandom_range(0, 99);
    if (pick < 20) c.action = ACT_INSERT_AT;
    else if (pick < 35) c.action = ACT_INSERT_FREE;
    else if (pick < 47) c.action = ACT_MODIFY;
    else if (pick < 60) c.action = ACT_DELETE;
    else if (pick < 68) c.action = ACT_FIND_FREE;
    else if (pick < 83) c.action = ACT_FIND_ID;
    else if (pick < 98) c.action = ACT_READ;
    else c.action = ACT_CLEAR;
    c.slot = (lim > 0 && $urandom_range(0, 9) < 8) ? SLOT_W'($urandom_range(0, lim - 1))
                                                   : SLOT_W'($urandom);
    c.key       = pick_key();
    c.name_word = {$urandom, $urandom};
    c.search_id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
                                              : ID_W'(id_counter + $urandom_range(0, spread) - 40);
    return c;
  endfunction

  // compare one response field
  task automatic check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // wait until no command is pending and every response is back
  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_queue.size() != 0 || cmd_valid || awaited_rsp.size() != 0);
  endtask

  // register write: setup cycle, then access cycle
  task automatic cfg_write(logic [1:0] index, logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_SLOTS_IN_USE: cfg_slots = value[SLOTS_IN_USE_W-1:0];
      REG_KEY_MIN:      cfg_key_lo = value[KEY_W-1:0];
      default:          cfg_key_hi = value[KEY_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_table(logic [SLOTS_IN_USE_W-1:0] slots, logic [KEY_W-1:0] lo,
                           logic [KEY_W-1:0] hi);
    wait_quiet();
    cfg_write(REG_SLOTS_IN_USE, PDATA_W'(slots));
    cfg_write(REG_KEY_MIN, PDATA_W'(lo));
    cfg_write(REG_KEY_MAX, PDATA_W'(hi));
  endtask

  task automatic random_phase(logic [SLOTS_IN_USE_W-1:0] slots, logic [KEY_W-1:0] lo,
                              logic [KEY_W-1:0] hi, int count, int cmd_max, int rsp_max,
                              logic squeeze);
    set_table(slots, lo, hi);
    cmd_gap_max  = cmd_max;
    rsp_wait_max = rsp_max;
    if (squeeze) pressure_arm = 1'b1;
    repeat (count) cmd_queue.push_back(random_command(count / 2));
  endtask

  // command driver: one transaction per queued item, random gap after each
  always @(negedge clk) begin : cmd_drive
    logic offer;
    offer = cmd_valid;
    if (cmd_fired) offer = 1'b0;
    if (!offer && !rst) begin
      if (cmd_gap > 0) cmd_gap--;
      else if (cmd_queue.size() != 0) begin
        cmd     <= cmd_queue.pop_front();
        offer   = 1'b1;
        cmd_gap = $urandom_range(0, cmd_gap_max);
      end
    end
    cmd_valid <= offer;
  end

  // response stall: random wait per transaction, plus one long hold when armed
  always @(negedge clk) begin : rsp_drive
    logic hold;
    if (rsp_fired) rsp_wait = $urandom_range(0, rsp_wait_max);
    if (pressure_arm && !pressure_done) begin
      hold_left     = PRESSURE_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (rsp_wait > 0) begin
      rsp_wait--;
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
    rsp_stall <= hold;
  end

  // monitor: check responses, then predict for newly accepted commands
  always @(posedge clk) begin : observe
    rslt_out_t want;
    cmd_fired <= !rst && cmd_valid && !cmd_stall;
    rsp_fired <= !rst && rsp_valid && !rsp_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        if (mismatches < 10) $display("%0t: response with none outstanding: %h", $time, rsp);
        mismatches++;
      end else begin
        want = awaited_rsp.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("result_slot", want.result_slot, rsp.result_slot);
        check_field("result_id", want.result_id, rsp.result_id);
        check_field("result_key", want.result_key, rsp.result_key);
        check_field("result_name", want.result_name, rsp.result_name);
      end
    end
    if (!rst && cmd_valid && !cmd_stall) awaited_rsp.push_back(apply_command(cmd));
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin : watchdog
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] slot63_id;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: empty table, inserts, modify keeping id, lookups, delete, clear
    set_table(7'd64, '0, KEY_MAX_RESET);
    queue_command(ACT_READ, 6'd0, '0, '0, '0);
    queue_command(ACT_DELETE, 6'd5, '0, '0, '0);
    queue_command(ACT_MODIFY, 6'd5, 31'd7, 64'h1, '0);
    queue_command(ACT_FIND_ID, 6'd0, '0, '0, '0);
    queue_command(ACT_INSERT_AT, 6'd0, '0, '0, '0);
    queue_command(ACT_INSERT_AT, 6'd63, KEY_MAX_RESET, '1, '1);
    queue_command(ACT_INSERT_AT, 6'd0, 31'd5, 64'h55, '0);
    queue_command(ACT_INSERT_FREE, 6'd40, 31'd12345, 64'h0123456789abcdef, '0);
    queue_command(ACT_MODIFY, 6'd1, KEY_MAX_RESET, 64'hfedcba9876543210, '0);
    queue_command(ACT_FIND_ID, '1, '0, '0, 16'd3);
    queue_command(ACT_FIND_ID, '0, '0, '0, '1);
    queue_command(ACT_DELETE, 6'd0, '0, '0, '0);
    queue_command(ACT_FIND_FREE, '0, '0, '0, '0);
    queue_command(ACT_CLEAR, '1, '1, '1, '1);
    queue_command(ACT_INSERT_FREE, 6'd0, 31'd9, 64'h8000000000000001, '0);

    // narrow table and key window: bad slot, bad key, keys at both bounds
    set_table(7'd4, 31'd10, 31'd20);
    queue_command(ACT_INSERT_AT, 6'd4, 31'd15, 64'h2, '0);
    queue_command(ACT_INSERT_AT, 6'd2, 31'd9, 64'h3, '0);
    queue_command(ACT_INSERT_AT, 6'd2, 31'd21, 64'h4, '0);
    queue_command(ACT_INSERT_AT, 6'd2, 31'd10, 64'h5, '0);
    queue_command(ACT_INSERT_FREE, '0, 31'd20, 64'h6, '0);
    queue_command(ACT_INSERT_FREE, '0, 31'd15, 64'h7, '0);
    queue_command(ACT_FIND_FREE, '0, '0, '0, '0);
    queue_command(ACT_INSERT_FREE, '0, 31'd5, 64'h8, '0);
    queue_command(ACT_MODIFY, 6'd2, 31'd30, 64'h9, '0);

    // zero limit: every slot is out of range
    set_table(7'd0, 31'd10, 31'd20);
    queue_command(ACT_FIND_FREE, '0, '0, '0, '0);
    queue_command(ACT_FIND_ID, '0, '0, '0, 16'd4);
    queue_command(ACT_READ, 6'd0, '0, '0, '0);

    // crossed key bounds reject every key
    set_table(7'd64, 31'd20, 31'd10);
    queue_command(ACT_INSERT_AT, 6'd10, 31'd15, 64'ha, '0);

    // id churn: slot 63 keeps its id while slot 0 is filled and emptied back to back
    set_table(7'd64, '0, KEY_MAX_RESET);
    cmd_gap_max  = 0;
    rsp_wait_max = 0;
    slot63_id = (id_counter == '1) ? ID_W'(1) : id_counter + 1'b1;
    queue_command(ACT_CLEAR, '0, '0, '0, '0);
    queue_command(ACT_INSERT_AT, 6'd63, 31'd1, 64'hcafe, '0);
    for (int n = 0; n < CHURN_PAIRS; n++) begin
      queue_command(ACT_INSERT_AT, 6'd0, KEY_W'(n), {$urandom, $urandom}, '0);
      queue_command(ACT_DELETE, 6'd0, '0, '0, '0);
    end
    queue_command(ACT_INSERT_AT, 6'd0, 31'd2, 64'hbeef, '0);
    queue_command(ACT_FIND_ID, '0, '0, '0, slot63_id);
    queue_command(ACT_DELETE, 6'd0, '0, '0, '0);
    queue_command(ACT_FIND_ID, '0, '0, '0, slot63_id);

    // random phases across table sizes and key windows
    random_phase(7'd64, '0, KEY_MAX_RESET, 340, 9, 9, 1'b0);
    random_phase(7'd8, 31'd100, 31'd5000, 200, 0, 0, 1'b0);
    random_phase(7'd127, '0, KEY_MAX_RESET, 150, 0, 9, 1'b1);
    random_phase(7'd1, '0, KEY_MAX_RESET, 100, 9, 0, 1'b0);
    random_phase(7'd0, '0, '0, 50, 9, 9, 1'b0);
    random_phase(7'd33, 31'd777, 31'd777, 150, 3, 9, 1'b0);
    random_phase(7'd40, 31'd5000, 31'd10, 100, 9, 3, 1'b0);
    random_phase(7'd64, KEY_MAX_RESET, KEY_MAX_RESET, 100, 9, 9, 1'b0);
    random_phase(7'd64, '0, KEY_MAX_RESET, 150, 9, 9, 1'b0);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ record_slot_table.f @@
src/rslt_pkg.sv
src/rslt_ram.sv
src/record_slot_table.sv
tb/sv/tb_record_slot_table.sv
